@@ hw/rtl/v4n_pkg.sv @@
`default_nettype none
package v4n_pkg;

  localparam int unsigned COMPONENT_WIDTH = 24;
  localparam int unsigned FRACTION_BITS   = 23;
  // fraction bits of the internal length
  localparam int unsigned LEN_FRAC        = 8;
  localparam int unsigned LANES           = 4;

endpackage
`default_nettype wire

@@ hw/rtl/v4n_vec_if.sv @@
`default_nettype none
interface v4n_vec_if #(
  parameter int unsigned ComponentWidth = v4n_pkg::COMPONENT_WIDTH
);
  logic                             valid;
  logic                             ready;
  logic signed [ComponentWidth-1:0] comp_x;
  logic signed [ComponentWidth-1:0] comp_y;
  logic signed [ComponentWidth-1:0] comp_z;
  logic signed [ComponentWidth-1:0] comp_w;

  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/v4n_unit_if.sv @@
`default_nettype none
interface v4n_unit_if #(
  parameter int unsigned ComponentWidth = v4n_pkg::COMPONENT_WIDTH,
  parameter int unsigned FractionBits   = v4n_pkg::FRACTION_BITS
);
  logic                             valid;
  logic                             ready;
  logic signed [FractionBits+1:0]   unit_x;
  logic signed [FractionBits+1:0]   unit_y;
  logic signed [FractionBits+1:0]   unit_z;
  logic signed [FractionBits+1:0]   unit_w;
  logic        [ComponentWidth:0]   vector_length;
  logic                             zero_vector;

  modport source (output valid, unit_x, unit_y, unit_z, unit_w, vector_length, zero_vector,
                  input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, unit_w, vector_length, zero_vector,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vector4_normalize.sv @@
// channel   | direction | word
// in_vec_i  | in        | comp_x, comp_y, comp_z, comp_w
// out_vec_o | out       | unit_x..unit_w, vector_length, zero_vector
//
// one word per cycle while the output is not stalled: abs, square and sum
// stages, one root bit per stage, one quotient bit per stage for all four
// lanes, then the output register.
// rst_ni clears the valid bits only; payload registers are not reset.
// a stalled output word freezes the whole pipeline, nothing is dropped.
`default_nettype none
module vector4_normalize #(
  parameter int unsigned ComponentWidth = v4n_pkg::COMPONENT_WIDTH,
  parameter int unsigned FractionBits   = v4n_pkg::FRACTION_BITS
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  v4n_vec_if.sink     in_vec_i,
  v4n_unit_if.source  out_vec_o
);

  localparam int unsigned CW = ComponentWidth;
  localparam int unsigned F  = FractionBits;
  localparam int unsigned LF = v4n_pkg::LEN_FRAC;
  localparam int unsigned NL = v4n_pkg::LANES;
  localparam int unsigned SW = 2 * CW + 2;
  localparam int unsigned RB = CW + 1 + LF;
  localparam int unsigned RW = 2 * RB;
  localparam int unsigned DS = F + LF;
  localparam int unsigned QW = DS + 1;
  localparam int unsigned UW = F + 2;
  localparam logic [QW-1:0] UnitOne = QW'(1) << F;

  logic adv;

  // abs stage
  logic [CW-1:0]   mag_a_q [NL];
  logic [NL-1:0]   neg_a_q;
  logic            v_a_q;
  logic [CW-1:0]   comp_in [NL];

  // square stage
  logic [2*CW-1:0] sq_b_q  [NL];
  logic [CW-1:0]   mag_b_q [NL];
  logic [NL-1:0]   neg_b_q;
  logic            v_b_q;

  // sum stage
  logic [SW-1:0]   s_c_q;
  logic [CW-1:0]   mag_c_q [NL];
  logic [NL-1:0]   neg_c_q;
  logic            v_c_q;

  // root pipeline, index 0 is the sum stage
  logic [RW-1:0]   sr_rad  [RB+1];
  logic [RB:0]     sr_rem  [RB+1];
  logic [RB-1:0]   sr_root [RB+1];
  logic [CW-1:0]   sr_mag  [RB+1][NL];
  logic [NL-1:0]   sr_neg  [RB+1];
  logic            sr_z    [RB+1];
  logic            sr_v    [RB+1];

  // divide pipeline, index 0 is the last root stage
  logic [RB:0]     dv_r [DS+1][NL];
  logic [QW-1:0]   dv_q [DS+1][NL];
  logic [RB-1:0]   dv_d [DS+1];
  logic [NL-1:0]   dv_neg [DS+1];
  logic            dv_z [DS+1];
  logic            dv_v [DS+1];

  // output register
  logic [UW-1:0]   unit_q [NL];
  logic [CW:0]     len_q;
  logic            zero_q;
  logic            out_v_q;

  assign adv            = !out_v_q || out_vec_o.ready;
  assign in_vec_i.ready = adv;

  assign comp_in[0] = in_vec_i.comp_x;
  assign comp_in[1] = in_vec_i.comp_y;
  assign comp_in[2] = in_vec_i.comp_z;
  assign comp_in[3] = in_vec_i.comp_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
    end else if (adv) begin
      v_a_q <= in_vec_i.valid;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < NL; l++) begin
        mag_a_q[l] <= comp_in[l][CW-1] ? (~comp_in[l] + 1'b1) : comp_in[l];
        neg_a_q[l] <= comp_in[l][CW-1];
        sq_b_q[l]  <= mag_a_q[l] * mag_a_q[l];
        mag_b_q[l] <= mag_a_q[l];
        mag_c_q[l] <= mag_b_q[l];
      end
      neg_b_q <= neg_a_q;
      neg_c_q <= neg_b_q;
      s_c_q   <= SW'(sq_b_q[0]) + SW'(sq_b_q[1]) + SW'(sq_b_q[2]) + SW'(sq_b_q[3]);
    end
  end

  assign sr_rad[0]  = {s_c_q, (2 * LF)'(0)};
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_neg[0]  = neg_c_q;
  assign sr_z[0]    = (s_c_q == '0);
  assign sr_v[0]    = v_c_q;
  for (genvar l = 0; l < NL; l++) begin : g_sr_in
    assign sr_mag[0][l] = mag_c_q[l];
  end

  for (genvar k = 0; k < RB; k++) begin : g_root
    logic [RB+2:0] rem_t;
    logic [RB+2:0] trial;
    logic          ge;

    assign rem_t = {sr_rem[k], sr_rad[k][RW-1:RW-2]};
    assign trial = {1'b0, sr_root[k], 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v[k+1] <= 1'b0;
      end else if (adv) begin
        sr_v[k+1] <= sr_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sr_rad[k+1]  <= {sr_rad[k][RW-3:0], 2'b00};
        sr_rem[k+1]  <= ge ? (RB+1)'(rem_t - trial) : (RB+1)'(rem_t);
        sr_root[k+1] <= {sr_root[k][RB-2:0], ge};
        sr_mag[k+1]  <= sr_mag[k];
        sr_neg[k+1]  <= sr_neg[k];
        sr_z[k+1]    <= sr_z[k];
      end
    end
  end

  // magnitude is below the divisor, so the integer quotient is zero
  assign dv_d[0]   = sr_root[RB];
  assign dv_neg[0] = sr_neg[RB];
  assign dv_z[0]   = sr_z[RB];
  assign dv_v[0]   = sr_v[RB];
  for (genvar l = 0; l < NL; l++) begin : g_dv_in
    assign dv_r[0][l] = (RB+1)'(sr_mag[RB][l]);
    assign dv_q[0][l] = '0;
  end

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [RB:0] rt [NL];
    logic [NL-1:0] ge;

    for (genvar l = 0; l < NL; l++) begin : g_lane
      assign rt[l] = {dv_r[k][l][RB-1:0], 1'b0};
      assign ge[l] = (rt[l] >= {1'b0, dv_d[k]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int l = 0; l < NL; l++) begin
          dv_r[k+1][l] <= ge[l] ? (rt[l] - {1'b0, dv_d[k]}) : rt[l];
          dv_q[k+1][l] <= {dv_q[k][l][QW-2:0], ge[l]};
        end
        dv_d[k+1]   <= dv_d[k];
        dv_neg[k+1] <= dv_neg[k];
        dv_z[k+1]   <= dv_z[k];
      end
    end
  end

  logic [UW-1:0] unit_d [NL];
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      logic [UW-1:0] qs;
      qs = (dv_q[DS][l] > UnitOne) ? UW'(UnitOne) : UW'(dv_q[DS][l][F:0]);
      if (dv_z[DS]) begin
        unit_d[l] = '0;
      end else begin
        unit_d[l] = dv_neg[DS][l] ? (~qs + 1'b1) : qs;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_v[DS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      unit_q <= unit_d;
      len_q  <= dv_z[DS] ? '0 : dv_d[DS][RB-1:LF];
      zero_q <= dv_z[DS];
    end
  end

  assign out_vec_o.valid         = out_v_q;
  assign out_vec_o.unit_x        = unit_q[0];
  assign out_vec_o.unit_y        = unit_q[1];
  assign out_vec_o.unit_z        = unit_q[2];
  assign out_vec_o.unit_w        = unit_q[3];
  assign out_vec_o.vector_length = len_q;
  assign out_vec_o.zero_vector   = zero_q;

`ifndef SYNTHESIS
  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && zero_q |-> len_q == '0 && unit_q[0] == '0 && unit_q[3] == '0)
    else $error("zero vector with nonzero outputs");

  a_root_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(sr_v[RB]) && $stable(dv_v[DS]))
    else $error("pipeline moved during stall");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ($signed(unit_q[0]) <= $signed(UW'(UnitOne)))
             && ($signed(unit_q[0]) >= -$signed(UW'(UnitOne))))
    else $error("unit component out of range");

  a_nonzero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v[0] && !dv_z[0] |-> dv_d[0] != '0)
    else $error("zero divisor for nonzero vector");
`endif

endmodule
`default_nettype wire
